// File: src/qcoa_pkg.sv
// Shared types and constants for the quad corner order and angle check.
`timescale 1ns / 1ps

package qcoa_pkg;

    // Width of the squared cosine limit register, Q0.16
    localparam int LIMIT_W = 16;

    // Limit after reset: cos(80 deg) squared in Q0.16
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1976;

    // Number of corners in one quad
    localparam int NCORNER = 4;

    // Corner labels of one quad, as input indices
    typedef struct packed {
        logic [1:0] top_left;
        logic [1:0] top_right;
        logic [1:0] bottom_left;
        logic [1:0] bottom_right;
    } t_labels;

endpackage

// File: src/qcoa_mul.sv
// Two-stage unsigned multiplier built from four half-width partial products.
`timescale 1ns / 1ps

module qcoa_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [AW-1:0]   i_a,
    input  logic [BW-1:0]   i_b,
    output logic [AW+BW-1:0] o_p
);

    localparam int LA = (AW + 1) / 2;
    localparam int HA = AW - LA;
    localparam int LB = (BW + 1) / 2;
    localparam int HB = BW - LB;
    localparam int PW = AW + BW;

    logic [LA+LB-1:0] r_ll;
    logic [LA+HB-1:0] r_lh;
    logic [HA+LB-1:0] r_hl;
    logic [HA+HB-1:0] r_hh;
    logic [PW-1:0]    r_p;

    // Form the four partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= (LA+LB)'(i_a[LA-1:0]) * (LA+LB)'(i_b[LB-1:0]);
            r_lh <= (LA+HB)'(i_a[LA-1:0]) * (LA+HB)'(i_b[BW-1:LB]);
            r_hl <= (HA+LB)'(i_a[AW-1:LA]) * (HA+LB)'(i_b[LB-1:0]);
            r_hh <= (HA+HB)'(i_a[AW-1:LA]) * (HA+HB)'(i_b[BW-1:LB]);
        end
    end

    // Align and sum the partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= PW'(r_ll) + (PW'(r_lh) << LB) + (PW'(r_hl) << LA)
                 + (PW'(r_hh) << (LA + LB));
        end
    end

    assign o_p = r_p;

endmodule

// File: src/quad_corner_order_and_angle_check.sv
// Top level: quad corner labelling and right-angle check pipeline.
`timescale 1ns / 1ps

// Takes one quad (four corners, signed fixed-point x and y) per cycle unless the
// output stalls, and returns the input indices of the top-left, top-right,
// bottom-left and bottom-right corners together with a flag that is set when
// every corner angle lies within the programmed tolerance of ninety degrees. The
// check is exact: dot^2 * 2^16 <= cos_sq_limit * |v1|^2 * |v2|^2, with
// cos_sq_limit in Q0.16 (reset value 1976, i.e. 80 to 100 degrees). Throughput is
// one item per clock unless the output stalls. The datapath has ten register
// stages, of which the split multipliers (squares and products of lengths, then
// the limit scaling) take two stages each. The whole pipeline halts as one while
// the output item waits, so a stall holds every stage in place. Write the limit
// only while no item is in flight.
module quad_corner_order_and_angle_check #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [qcoa_pkg::LIMIT_W-1:0] i_cfg_data,
    // input items
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [COORD_BITS-1:0] i_corner_x0,
    input  logic signed [COORD_BITS-1:0] i_corner_y0,
    input  logic signed [COORD_BITS-1:0] i_corner_x1,
    input  logic signed [COORD_BITS-1:0] i_corner_y1,
    input  logic signed [COORD_BITS-1:0] i_corner_x2,
    input  logic signed [COORD_BITS-1:0] i_corner_y2,
    input  logic signed [COORD_BITS-1:0] i_corner_x3,
    input  logic signed [COORD_BITS-1:0] i_corner_y3,
    // result items
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_top_left_index,
    output logic [1:0]                   o_top_right_index,
    output logic [1:0]                   o_bottom_left_index,
    output logic [1:0]                   o_bottom_right_index,
    output logic                         o_angles_ok
);

    import qcoa_pkg::*;

    localparam int CW   = COORD_BITS;
    localparam int DW   = CW + 1;          // edge vector component
    localparam int PW   = 2 * DW;          // signed product and dot product
    localparam int MW   = 2 * CW + 1;      // squared length, dot magnitude
    localparam int QW   = 2 * MW;          // dot^2 and |v1|^2 * |v2|^2
    localparam int RW   = QW + LIMIT_W;    // scaled right-hand side
    localparam int NSTG = 10;

    // ------------------------------------------------------------------
    // Control: valid bits and global advance
    // ------------------------------------------------------------------
    logic              en;
    logic [NSTG:1]     r_vld;
    logic [LIMIT_W-1:0] r_cos_sq_limit;

    assign en          = !r_vld[NSTG] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[NSTG];
    assign o_cfg_ready = 1'b1;

    // Advance the valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-1:1], i_in_valid};
        end
    end

    // Hold the angle limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_sq_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_cos_sq_limit <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture corners
    // ------------------------------------------------------------------
    logic signed [CW-1:0] r_cx [NCORNER];
    logic signed [CW-1:0] r_cy [NCORNER];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx[0] <= i_corner_x0;
            r_cy[0] <= i_corner_y0;
            r_cx[1] <= i_corner_x1;
            r_cy[1] <= i_corner_y1;
            r_cx[2] <= i_corner_x2;
            r_cy[2] <= i_corner_y2;
            r_cx[3] <= i_corner_x3;
            r_cy[3] <= i_corner_y3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: vertex vectors and pairwise coordinate compares
    // ------------------------------------------------------------------
    logic signed [DW-1:0] r_v1x [NCORNER];
    logic signed [DW-1:0] r_v1y [NCORNER];
    logic signed [DW-1:0] r_v2x [NCORNER];
    logic signed [DW-1:0] r_v2y [NCORNER];
    logic [NCORNER-1:0]   r_xlt [NCORNER];
    logic [NCORNER-1:0]   r_ylt [NCORNER];

    // Vertex k+1 sees neighbours k and k+2
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NCORNER; k++) begin
                r_v1x[k] <= DW'(r_cx[k]) - DW'(r_cx[2'(k + 1)]);
                r_v1y[k] <= DW'(r_cy[k]) - DW'(r_cy[2'(k + 1)]);
                r_v2x[k] <= DW'(r_cx[2'(k + 2)]) - DW'(r_cx[2'(k + 1)]);
                r_v2y[k] <= DW'(r_cy[2'(k + 2)]) - DW'(r_cy[2'(k + 1)]);
                for (int j = 0; j < NCORNER; j++) begin
                    r_xlt[k][j] <= r_cx[k] < r_cx[j];
                    r_ylt[k][j] <= r_cy[k] < r_cy[j];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: products per vertex, corner labels
    // ------------------------------------------------------------------
    logic signed [PW-1:0] r_pxx [NCORNER];
    logic signed [PW-1:0] r_pyy [NCORNER];
    logic signed [PW-1:0] r_s1x [NCORNER];
    logic signed [PW-1:0] r_s1y [NCORNER];
    logic signed [PW-1:0] r_s2x [NCORNER];
    logic signed [PW-1:0] r_s2y [NCORNER];
    t_labels              n_lab;
    t_labels              r_lab [3:NSTG];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NCORNER; k++) begin
                r_pxx[k] <= PW'(r_v1x[k]) * PW'(r_v2x[k]);
                r_pyy[k] <= PW'(r_v1y[k]) * PW'(r_v2y[k]);
                r_s1x[k] <= PW'(r_v1x[k]) * PW'(r_v1x[k]);
                r_s1y[k] <= PW'(r_v1y[k]) * PW'(r_v1y[k]);
                r_s2x[k] <= PW'(r_v2x[k]) * PW'(r_v2x[k]);
                r_s2y[k] <= PW'(r_v2y[k]) * PW'(r_v2y[k]);
            end
        end
    end

    // Pick the two top corners by y, order each pair by x
    always_comb begin
        logic [1:0] lt;
        logic [1:0] rt;
        logic [1:0] sw;
        logic [1:0] ia;
        logic [1:0] ib;
        logic       rt_found;
        logic       a_found;
        lt       = 2'd0;
        rt       = 2'd0;
        sw       = 2'd0;
        ia       = 2'd0;
        ib       = 2'd0;
        rt_found = 1'b0;
        a_found  = 1'b0;
        for (int i = 1; i < NCORNER; i++) begin
            if (r_ylt[2'(i)][lt]) begin
                lt = 2'(i);
            end
        end
        for (int i = 0; i < NCORNER; i++) begin
            if (2'(i) != lt) begin
                if (!rt_found || r_ylt[2'(i)][rt]) begin
                    rt       = 2'(i);
                    rt_found = 1'b1;
                end
            end
        end
        // left top is the one with the smaller x
        if (r_xlt[rt][lt]) begin
            sw = lt;
            lt = rt;
            rt = sw;
        end
        for (int i = 0; i < NCORNER; i++) begin
            if (2'(i) != lt && 2'(i) != rt) begin
                if (!a_found) begin
                    ia      = 2'(i);
                    a_found = 1'b1;
                end else begin
                    ib = 2'(i);
                end
            end
        end
        n_lab.top_left  = lt;
        n_lab.top_right = rt;
        // on equal x the later index goes left
        if (!r_xlt[ia][ib]) begin
            n_lab.bottom_left  = ib;
            n_lab.bottom_right = ia;
        end else begin
            n_lab.bottom_left  = ia;
            n_lab.bottom_right = ib;
        end
    end

    // Carry the labels alongside the angle datapath
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lab[3] <= n_lab;
            for (int s = 4; s <= NSTG; s++) begin
                r_lab[s] <= r_lab[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: dot product and squared lengths
    // ------------------------------------------------------------------
    logic signed [PW-1:0] r_dot [NCORNER];
    logic [MW-1:0]        r_l1  [NCORNER];
    logic [MW-1:0]        r_l2  [NCORNER];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NCORNER; k++) begin
                r_dot[k] <= r_pxx[k] + r_pyy[k];
                r_l1[k]  <= MW'(r_s1x[k]) + MW'(r_s1y[k]);
                r_l2[k]  <= MW'(r_s2x[k]) + MW'(r_s2y[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: dot magnitude
    // ------------------------------------------------------------------
    logic [MW-1:0] r_dmag [NCORNER];
    logic [MW-1:0] r_l1b  [NCORNER];
    logic [MW-1:0] r_l2b  [NCORNER];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NCORNER; k++) begin
                r_dmag[k] <= r_dot[k][PW-1] ? MW'(-r_dot[k]) : MW'(r_dot[k]);
                r_l1b[k]  <= r_l1[k];
                r_l2b[k]  <= r_l2[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 6 to 9: dot^2, length product, limit scaling
    // ------------------------------------------------------------------
    logic [QW-1:0] dsq   [NCORNER];
    logic [QW-1:0] lprod [NCORNER];
    logic [RW-1:0] rhs   [NCORNER];
    logic [QW-1:0] r_dsq8 [NCORNER];
    logic [QW-1:0] r_dsq9 [NCORNER];

    for (genvar g = 0; g < NCORNER; g++) begin : g_vertex
        qcoa_mul #(.AW(MW), .BW(MW)) u_dsq (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r_dmag[g]),
            .i_b   (r_dmag[g]),
            .o_p   (dsq[g])
        );

        qcoa_mul #(.AW(MW), .BW(MW)) u_lprod (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r_l1b[g]),
            .i_b   (r_l2b[g]),
            .o_p   (lprod[g])
        );

        qcoa_mul #(.AW(QW), .BW(LIMIT_W)) u_scale (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (lprod[g]),
            .i_b   (r_cos_sq_limit),
            .o_p   (rhs[g])
        );
    end

    // Delay dot^2 to meet the scaled length product
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NCORNER; k++) begin
                r_dsq8[k] <= dsq[k];
                r_dsq9[k] <= r_dsq8[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: compare and output register
    // ------------------------------------------------------------------
    logic n_ok;
    logic r_ok;

    // dot^2 carries the Q0.16 scale of the limit
    always_comb begin
        n_ok = 1'b1;
        for (int k = 0; k < NCORNER; k++) begin
            if ({r_dsq9[k], {LIMIT_W{1'b0}}} > rhs[k]) begin
                n_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ok <= n_ok;
        end
    end

    assign o_top_left_index     = r_lab[NSTG].top_left;
    assign o_top_right_index    = r_lab[NSTG].top_right;
    assign o_bottom_left_index  = r_lab[NSTG].bottom_left;
    assign o_bottom_right_index = r_lab[NSTG].bottom_right;
    assign o_angles_ok          = r_ok;

`ifndef SYNTHESIS
    // The four labels name four different corners
    a_labels_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (((4'b1 << o_top_left_index) | (4'b1 << o_top_right_index)
                        | (4'b1 << o_bottom_left_index) | (4'b1 << o_bottom_right_index))
                        == 4'hF))
        else $error("corner labels are not a permutation");

    // An accepted item enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[1])
        else $error("accepted item lost at pipeline entry");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

    // Reset restores the default limit
    a_reset_limit: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_cos_sq_limit == LIMIT_RESET))
        else $error("angle limit not restored by reset");
`endif

endmodule

// File: bench/tb_top.sv
// Testbench for the quad corner labelling and right-angle check block.
`timescale 1ns / 1ps

module tb_top;

    import qcoa_pkg::*;

    localparam int CW         = 16;
    localparam int LATENCY    = 10;
    localparam int STALL_MAX  = 2000;
    localparam int PHASE_LEN  = 85;

    // One queued job: either a quad or a write of the angle limit
    typedef struct packed {
        logic               is_limit;
        logic [LIMIT_W-1:0] limit;
        logic [3:0][CW-1:0] qx;
        logic [3:0][CW-1:0] qy;
    } t_job;

    // Labels and angle flag predicted for one quad
    typedef struct packed {
        t_labels lab;
        logic    ok;
    } t_verdict;

    // Predicted verdict with the cycle its quad was taken
    typedef struct packed {
        t_verdict    v;
        logic [31:0] stamp;
    } t_expect;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [LIMIT_W-1:0] i_cfg_data  = '0;

    logic          i_in_valid  = 1'b0;
    logic          o_in_ready;
    logic [CW-1:0] i_corner_x0 = '0;
    logic [CW-1:0] i_corner_y0 = '0;
    logic [CW-1:0] i_corner_x1 = '0;
    logic [CW-1:0] i_corner_y1 = '0;
    logic [CW-1:0] i_corner_x2 = '0;
    logic [CW-1:0] i_corner_y2 = '0;
    logic [CW-1:0] i_corner_x3 = '0;
    logic [CW-1:0] i_corner_y3 = '0;

    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [1:0] o_top_left_index;
    logic [1:0] o_top_right_index;
    logic [1:0] o_bottom_left_index;
    logic [1:0] o_bottom_right_index;
    logic       o_angles_ok;

    t_job    job_q[$];
    t_expect verdict_q[$];

    logic [LIMIT_W-1:0] limit_now    = LIMIT_RESET;
    logic [31:0]        cycle        = '0;
    int                 n_quads_in   = 0;
    int                 n_quads_out  = 0;
    int                 n_errors     = 0;
    int                 stall_cycles = 0;

    quad_corner_order_and_angle_check #(
        .COORD_BITS(CW)
    ) DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_corner_x0         (i_corner_x0),
        .i_corner_y0         (i_corner_y0),
        .i_corner_x1         (i_corner_x1),
        .i_corner_y1         (i_corner_y1),
        .i_corner_x2         (i_corner_x2),
        .i_corner_y2         (i_corner_y2),
        .i_corner_x3         (i_corner_x3),
        .i_corner_y3         (i_corner_y3),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_top_left_index    (o_top_left_index),
        .o_top_right_index   (o_top_right_index),
        .o_bottom_left_index (o_bottom_left_index),
        .o_bottom_right_index(o_bottom_right_index),
        .o_angles_ok         (o_angles_ok)
    );

    // Label the corners and test every vertex angle against the limit
    function automatic t_verdict label_and_check(input logic [3:0][CW-1:0] qx,
                                                 input logic [3:0][CW-1:0] qy,
                                                 input logic [LIMIT_W-1:0] lim);
        t_verdict           res;
        logic signed [127:0] x1, y1, x2, y2, dot, len1, len2, lhs, rhs, lim_w;
        int                 i, c, p, q, lt, rt, a, b, t;
        res.ok = 1'b1;
        lim_w  = $signed({112'd0, lim});
        for (i = 0; i < 4; i++) begin
            c    = (i + 1) & 3;
            p    = i;
            q    = (i + 2) & 3;
            x1   = $signed(qx[p]) - $signed(qx[c]);
            y1   = $signed(qy[p]) - $signed(qy[c]);
            x2   = $signed(qx[q]) - $signed(qx[c]);
            y2   = $signed(qy[q]) - $signed(qy[c]);
            dot  = x1 * x2 + y1 * y2;
            len1 = x1 * x1 + y1 * y1;
            len2 = x2 * x2 + y2 * y2;
            lhs  = dot * dot * 65536;
            rhs  = lim_w * len1 * len2;
            if (lhs > rhs)
                res.ok = 1'b0;
        end
        // first lowest y, then first lowest y of the rest
        lt = 0;
        for (i = 1; i < 4; i++)
            if ($signed(qy[i]) < $signed(qy[lt]))
                lt = i;
        rt = -1;
        for (i = 0; i < 4; i++) begin
            if (i != lt) begin
                if (rt < 0)
                    rt = i;
                else if ($signed(qy[i]) < $signed(qy[rt]))
                    rt = i;
            end
        end
        if ($signed(qx[lt]) > $signed(qx[rt])) begin
            t  = lt;
            lt = rt;
            rt = t;
        end
        // remaining pair in index order; a tie in x goes to the later one
        a = -1;
        b = -1;
        for (i = 0; i < 4; i++) begin
            if (i != lt && i != rt) begin
                if (a < 0)
                    a = i;
                else
                    b = i;
            end
        end
        res.lab.top_left  = lt[1:0];
        res.lab.top_right = rt[1:0];
        if ($signed(qx[b]) <= $signed(qx[a])) begin
            res.lab.bottom_left  = b[1:0];
            res.lab.bottom_right = a[1:0];
        end else begin
            res.lab.bottom_left  = a[1:0];
            res.lab.bottom_right = b[1:0];
        end
        return res;
    endfunction

    task automatic add_quad(input int x0, input int y0, input int x1, input int y1,
                            input int x2, input int y2, input int x3, input int y3);
        t_job j;
        j.is_limit = 1'b0;
        j.limit    = '0;
        j.qx       = {x3[CW-1:0], x2[CW-1:0], x1[CW-1:0], x0[CW-1:0]};
        j.qy       = {y3[CW-1:0], y2[CW-1:0], y1[CW-1:0], y0[CW-1:0]};
        job_q.push_back(j);
    endtask

    task automatic add_limit(input logic [LIMIT_W-1:0] v);
        t_job j;
        j          = '0;
        j.is_limit = 1'b1;
        j.limit    = v;
        job_q.push_back(j);
    endtask

    task automatic check_field(input string name, input logic [1:0] want,
                               input logic [1:0] got);
        if (want !== got) begin
            n_errors++;
            if (n_errors <= 10)
                $display("mismatch %0s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Clock
    always #10 i_clk = ~i_clk;

    // Count cycles for stamping predictions
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
    end

    // Drive quads and limit writes from the job queue
    always @(posedge i_clk) begin : drive_proc
        t_job     job;
        t_expect  pred;
        logic     item_taken, limit_taken, hold_item, hold_limit, drained, calm;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            item_taken  = i_in_valid && o_in_ready;
            limit_taken = i_cfg_valid && o_cfg_ready;
            hold_item   = i_in_valid && !item_taken;
            hold_limit  = i_cfg_valid && !limit_taken;
            drained     = !item_taken && (n_quads_in == n_quads_out);
            calm        = (n_quads_in >= 150) && (n_quads_in < 300);
            // predict the quad taken at this edge
            if (item_taken) begin
                pred.v     = label_and_check({i_corner_x3, i_corner_x2,
                                              i_corner_x1, i_corner_x0},
                                             {i_corner_y3, i_corner_y2,
                                              i_corner_y1, i_corner_y0},
                                             limit_now);
                pred.stamp = cycle;
                verdict_q.push_back(pred);
                n_quads_in <= n_quads_in + 1;
            end
            if (limit_taken)
                limit_now <= i_cfg_data;
            // load the next job; a limit write waits for the pipe to empty
            if (!hold_item && !hold_limit && job_q.size() != 0) begin
                job = job_q[0];
                if (job.is_limit) begin
                    if (drained) begin
                        job        = job_q.pop_front();
                        hold_limit = 1'b1;
                        i_cfg_data <= job.limit;
                    end
                end else if (calm || $urandom_range(0, 99) >= 10) begin
                    job         = job_q.pop_front();
                    hold_item   = 1'b1;
                    i_corner_x0 <= job.qx[0];
                    i_corner_y0 <= job.qy[0];
                    i_corner_x1 <= job.qx[1];
                    i_corner_y1 <= job.qy[1];
                    i_corner_x2 <= job.qx[2];
                    i_corner_y2 <= job.qy[2];
                    i_corner_x3 <= job.qx[3];
                    i_corner_y3 <= job.qy[3];
                end
            end
            i_in_valid  <= hold_item;
            i_cfg_valid <= hold_limit;
        end
    end

    // Take results and compare with the oldest prediction
    always @(posedge i_clk) begin : watch_proc
        t_expect head;
        logic    calm;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            calm = (n_quads_out >= 150) && (n_quads_out < 300);
            if (o_out_valid && i_out_ready) begin
                n_quads_out <= n_quads_out + 1;
                if (verdict_q.size() != 0)
                    head = verdict_q[0];
                if (verdict_q.size() == 0 || head.stamp == cycle) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("result with no quad pending: %0d %0d %0d %0d ok=%0d",
                                 o_top_left_index, o_top_right_index,
                                 o_bottom_left_index, o_bottom_right_index,
                                 o_angles_ok);
                end else begin
                    head = verdict_q.pop_front();
                    check_field("top_left", head.v.lab.top_left, o_top_left_index);
                    check_field("top_right", head.v.lab.top_right, o_top_right_index);
                    check_field("bottom_left", head.v.lab.bottom_left,
                                o_bottom_left_index);
                    check_field("bottom_right", head.v.lab.bottom_right,
                                o_bottom_right_index);
                    check_field("angles_ok", {1'b0, head.v.ok}, {1'b0, o_angles_ok});
                end
            end
            i_out_ready <= calm || ($urandom_range(0, 99) >= 10);
        end
    end

    // Stop a run that makes no progress
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (i_cfg_valid && o_cfg_ready) ||
            (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Build the job list, release reset, wait for the pipe to drain
    initial begin : stim_proc
        int   ph, n, k, kind, cx0, cy0, ux, uy, vx, vy, m, jit, s, idx;
        int   px[4], py[4], qx[4], qy[4];
        logic rev;

        // directed quads at the reset limit
        add_quad(0, 0, 160, 0, 160, 160, 0, 160);
        add_quad(0, 0, 0, 0, 0, 0, 0, 0);
        add_quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767);
        add_quad(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        add_quad(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        add_quad(0, -100, 100, 0, 0, 100, -100, 0);
        add_quad(0, 0, 160, 0, 240, 160, 80, 160);
        add_quad(0, 0, 16, 16, 32, 32, 48, 48);
        add_quad(5, 5, 5, 5, 5, 5, 100, 200);
        add_quad(100, 0, 0, 0, 50, 80, 60, 80);
        add_quad(0, 0, 100, 0, 50, 90, 50, 95);
        add_quad(-32768, 32767, 32767, -32768, -1, 0, 0, -1);
        add_quad(160, 160, 0, 0, 160, 0, 0, 160);
        add_quad(0, 160, 160, 160, 160, 0, 0, 0);
        // strictest limit: only corners with a zero dot product pass
        add_limit(16'd0);
        add_quad(0, 0, 160, 0, 160, 160, 0, 160);
        add_quad(0, 0, 160, 1, 160, 160, 0, 160);
        add_quad(0, -100, 100, 0, 0, 100, -100, 0);
        // loosest limit: all but collinear or nearly collinear corners pass
        add_limit(16'hFFFF);
        add_quad(0, 0, 160, 0, 240, 160, 80, 160);
        add_quad(0, 0, 16, 16, 32, 32, 48, 48);
        add_quad(-32768, 32767, 32767, -32768, -1, 0, 0, -1);

        // random phases, each under its own limit
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       add_limit(LIMIT_RESET);
                1:       add_limit(16'd0);
                2:       add_limit(16'hFFFF);
                4:       add_limit(16'd8192);
                default: add_limit(16'($urandom));
            endcase
            for (n = 0; n < PHASE_LEN; n++) begin
                kind = $urandom_range(0, 99);
                if (kind < 50) begin
                    // rotated rectangle with some corner jitter, any start and winding
                    cx0 = int'($urandom_range(0, 16000)) - 8000;
                    cy0 = int'($urandom_range(0, 16000)) - 8000;
                    ux  = int'($urandom_range(0, 3000)) - 1500;
                    uy  = int'($urandom_range(0, 3000)) - 1500;
                    m   = $urandom_range(1, 8);
                    vx  = -uy * m / 4;
                    vy  = ux * m / 4;
                    case ($urandom_range(0, 3))
                        0:       jit = 0;
                        1:       jit = 2;
                        2:       jit = 50;
                        default: jit = 400;
                    endcase
                    px[0] = cx0 + ux + vx;  py[0] = cy0 + uy + vy;
                    px[1] = cx0 - ux + vx;  py[1] = cy0 - uy + vy;
                    px[2] = cx0 - ux - vx;  py[2] = cy0 - uy - vy;
                    px[3] = cx0 + ux - vx;  py[3] = cy0 + uy - vy;
                    s   = $urandom_range(0, 3);
                    rev = 1'($urandom_range(0, 1));
                    for (k = 0; k < 4; k++) begin
                        idx   = rev ? ((s - k + 4) & 3) : ((s + k) & 3);
                        qx[k] = px[idx] + int'($urandom_range(0, 2 * jit)) - jit;
                        qy[k] = py[idx] + int'($urandom_range(0, 2 * jit)) - jit;
                    end
                end else if (kind < 70) begin
                    // any bit pattern
                    for (k = 0; k < 4; k++) begin
                        qx[k] = $urandom;
                        qy[k] = $urandom;
                    end
                end else if (kind < 85) begin
                    // range extremes mixed with random values
                    for (k = 0; k < 8; k++) begin
                        case ($urandom_range(0, 4))
                            0:       idx = -32768;
                            1:       idx = 32767;
                            2:       idx = 0;
                            3:       idx = -1;
                            default: idx = $urandom;
                        endcase
                        if (k < 4)
                            qx[k] = idx;
                        else
                            qy[k - 4] = idx;
                    end
                end else begin
                    // few distinct values: ties in x and y, coincident corners
                    for (k = 0; k < 4; k++) begin
                        qx[k] = 16 * int'($urandom_range(0, 2));
                        qy[k] = 16 * int'($urandom_range(0, 2));
                    end
                end
                add_quad(qx[0], qy[0], qx[1], qy[1], qx[2], qy[2], qx[3], qy[3]);
            end
        end

        // hold reset, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every job to go in and every result to come out
        while (job_q.size() != 0 || i_in_valid || i_cfg_valid ||
               n_quads_out < n_quads_in)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            n_errors++;
            $display("%0d predicted results never arrived", verdict_q.size());
        end
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
